// ===== hw/rtl/pulse_beat_rate_detector_defines.svh =====
// Assertion macros for the pulse beat rate detector.
// Included by files that carry concurrent assertions; no other dependency.
`ifndef PULSE_BEAT_RATE_DETECTOR_DEFINES_SVH
`define PULSE_BEAT_RATE_DETECTOR_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define PBRD_ASSERT_SAME(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("pbrd same-cycle check failed");

// Condition implies consequence in the next cycle.
`define PBRD_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("pbrd next-cycle check failed");

`endif

// ===== hw/rtl/pbrd_pkg.sv =====
// Package for the pulse beat rate detector: field widths, register indexes,
// reset values and shared types. No dependencies.
package pbrd_pkg;

   localparam int IR_W       = 18;
   localparam int AC_W       = 19;
   localparam int ACC_W      = 24;
   localparam int ACD_W      = 25;
   localparam int TIME_W     = 32;
   localparam int INTERVAL_W = 16;
   localparam int RATE_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 19;
   localparam int DIV_W      = 16;
   localparam int DIV_CNT_W  = $clog2(DIV_W);

   localparam int HISTORY_DEPTH_DEF = 4;

   typedef logic [IR_W-1:0]          ir_type;
   typedef logic signed [AC_W-1:0]   ac_type;
   typedef logic signed [ACD_W-1:0]  acd_type;
   typedef logic [TIME_W-1:0]        time_type;
   typedef logic [INTERVAL_W-1:0]    interval_type;
   typedef logic [RATE_W-1:0]        rate_type;
   typedef logic [CSR_IDX_W-1:0]     csr_idx_type;
   typedef logic [CSR_DATA_W-1:0]    csr_data_type;

   localparam csr_idx_type CSR_FINGER  = 3'd0;
   localparam csr_idx_type CSR_ARM     = 3'd1;
   localparam csr_idx_type CSR_TRIGGER = 3'd2;
   localparam csr_idx_type CSR_MIN_INT = 3'd3;
   localparam csr_idx_type CSR_MAX_INT = 3'd4;

   localparam ir_type       FINGER_RST  = 18'd20000;
   localparam ac_type       ARM_RST     = 19'sd150;
   localparam ac_type       TRIGGER_RST = -19'sd50;
   localparam interval_type MIN_INT_RST = 16'd333;
   localparam interval_type MAX_INT_RST = 16'd1500;

   localparam logic [DIV_W-1:0] RATE_NUM = 16'd60000;
   localparam rate_type         RATE_SAT = 8'd255;

   localparam acd_type AC_MAX = 25'sd262143;
   localparam acd_type AC_MIN = -25'sd262144;

endpackage

// ===== hw/rtl/pulse_beat_rate_detector.sv =====
// Pulse beat rate detector top level: DC removal, beat detection, serial
// rate divider and history mean. Depends on pbrd_pkg and the defines header.
//
// Usage: the req channel carries one infrared sample and its millisecond
// timestamp; the rsp channel returns one result per request (finger flag,
// AC value, beat flag, averaged rate). Both are valid/ready. The csr port
// writes the five threshold registers by index. The user must write them
// only while the block is idle; the block itself does not enforce this.
// A no-finger request goes from the filter state to the done state, and a
// finger request without a beat goes through filter and detect. A request
// that yields a beat also runs one 16-step restoring divider to compute
// 60000/interval, stores the rate, sums the rate history over its
// HISTORY_DEPTH entries and runs the same divider 16 more steps for the mean
// (skipped if the history is all zero). req_ready is high only while the
// sequencer is idle, so a new request waits until the last one leaves it.
// The result sits in an output register; a new request is accepted while it
// waits, and the sequencer holds its next result until rsp_ready takes it.
// Reset (synchronous) restores register defaults, clears the filter,
// armed flag, last-beat time, history and slot, and drops any pending rsp.
`include "pulse_beat_rate_detector_defines.svh"

module pulse_beat_rate_detector #(
   parameter int HISTORY_DEPTH = pbrd_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  pbrd_pkg::ir_type        req_ir_sample,
   input  pbrd_pkg::time_type      req_now_ms,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_finger_present,
   output pbrd_pkg::ac_type        rsp_ac_value,
   output logic                    rsp_beat,
   output pbrd_pkg::rate_type      rsp_rate_bpm,
   input  logic                    csr_we,
   input  pbrd_pkg::csr_idx_type   csr_index,
   input  pbrd_pkg::csr_data_type  csr_data
);
   import pbrd_pkg::*;

   localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W  = RATE_W + CNT_W;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HISTORY_DEPTH - 1);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_FILTER   = 4'd1;
   localparam logic [3:0] S_DETECT   = 4'd2;
   localparam logic [3:0] S_DIV_RATE = 4'd3;
   localparam logic [3:0] S_STORE    = 4'd4;
   localparam logic [3:0] S_SUM      = 4'd5;
   localparam logic [3:0] S_MEAN     = 4'd6;
   localparam logic [3:0] S_DIV_MEAN = 4'd7;
   localparam logic [3:0] S_DONE     = 4'd8;

   logic [3:0]          state_ff;
   ir_type              finger_ff;
   ac_type              arm_ff;
   ac_type              trigger_ff;
   interval_type        min_int_ff;
   interval_type        max_int_ff;

   logic [ACC_W-1:0]    acc_ff;
   logic                armed_ff;
   time_type            last_ff;
   rate_type            history_ff [HISTORY_DEPTH];
   logic [SLOT_W-1:0]   slot_ff;

   ir_type              ir_ff;
   time_type            now_ff;
   acd_type             ac_ff;
   logic [SLOT_W-1:0]   idx_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [CNT_W-1:0]    cnt_ff;

   logic [DIV_W:0]      div_rem_ff;
   logic [DIV_W-1:0]    div_quo_ff;
   logic [DIV_W-1:0]    div_den_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;

   logic                res_finger_ff;
   ac_type              res_ac_ff;
   logic                res_beat_ff;
   rate_type            res_rate_ff;

   logic                rsp_valid_ff;
   logic                rsp_finger_ff;
   ac_type              rsp_ac_ff;
   logic                rsp_beat_ff;
   rate_type            rsp_rate_ff;

   logic [ACC_W+3:0]    acc_x15;
   logic [ACC_W-1:0]    acc_in;
   acd_type             ac_in;
   logic                arm_hit;
   logic                fire;
   time_type            delta;
   logic                in_window;
   logic                too_long;
   ac_type              ac_sat;
   logic [DIV_W:0]      div_shift;
   logic                div_fit;
   logic [DIV_W:0]      div_rem_in;
   logic [DIV_W-1:0]    div_quo_in;
   logic                div_last;
   rate_type            raw_sat;
   logic                rsp_free;

   always_comb begin
      acc_x15    = {acc_ff, 4'b0000} - {4'b0000, acc_ff};
      acc_in     = ACC_W'({7'd0, ir_ff} + {1'b0, acc_x15[ACC_W+3:4]});
      ac_in      = $signed({1'b0, acc_in}) - $signed({1'b0, acc_ff});
      arm_hit    = ac_ff > acd_type'(arm_ff);
      fire       = (ac_ff < acd_type'(trigger_ff)) && (armed_ff || arm_hit);
      delta      = now_ff - last_ff;
      in_window  = (delta > {16'd0, min_int_ff}) && (delta < {16'd0, max_int_ff});
      too_long   = delta >= {16'd0, max_int_ff};
      if (ac_ff > AC_MAX) begin
         ac_sat = AC_W'(AC_MAX);
      end else if (ac_ff < AC_MIN) begin
         ac_sat = AC_W'(AC_MIN);
      end else begin
         ac_sat = ac_ff[AC_W-1:0];
      end
      div_shift  = {div_rem_ff[DIV_W-1:0], div_quo_ff[DIV_W-1]};
      div_fit    = div_shift >= {1'b0, div_den_ff};
      div_rem_in = div_fit ? (div_shift - {1'b0, div_den_ff}) : div_shift;
      div_quo_in = {div_quo_ff[DIV_W-2:0], div_fit};
      div_last   = div_cnt_ff == DIV_CNT_W'(DIV_W - 1);
      raw_sat    = (div_quo_ff > DIV_W'(RATE_SAT)) ? RATE_SAT : div_quo_ff[RATE_W-1:0];
      rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         finger_ff    <= FINGER_RST;
         arm_ff       <= ARM_RST;
         trigger_ff   <= TRIGGER_RST;
         min_int_ff   <= MIN_INT_RST;
         max_int_ff   <= MAX_INT_RST;
         acc_ff       <= '0;
         armed_ff     <= 1'b0;
         last_ff      <= '0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            history_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_FINGER:  finger_ff  <= csr_data[IR_W-1:0];
               CSR_ARM:     arm_ff     <= csr_data;
               CSR_TRIGGER: trigger_ff <= csr_data;
               CSR_MIN_INT: min_int_ff <= csr_data[INTERVAL_W-1:0];
               CSR_MAX_INT: max_int_ff <= csr_data[INTERVAL_W-1:0];
               default: ;
            endcase
         end

         if (rsp_valid_ff && rsp_ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  ir_ff    <= req_ir_sample;
                  now_ff   <= req_now_ms;
                  state_ff <= S_FILTER;
               end
            end
            S_FILTER: begin
               res_beat_ff <= 1'b0;
               res_rate_ff <= '0;
               if (ir_ff < finger_ff) begin
                  acc_ff        <= '0;
                  res_finger_ff <= 1'b0;
                  res_ac_ff     <= '0;
                  state_ff      <= S_DONE;
               end else begin
                  acc_ff        <= acc_in;
                  ac_ff         <= ac_in;
                  res_finger_ff <= 1'b1;
                  state_ff      <= S_DETECT;
               end
            end
            S_DETECT: begin
               res_ac_ff <= ac_sat;
               if (fire) begin
                  armed_ff <= 1'b0;
                  if (in_window) begin
                     div_rem_ff <= '0;
                     div_quo_ff <= RATE_NUM;
                     div_den_ff <= delta[DIV_W-1:0];
                     div_cnt_ff <= '0;
                     state_ff   <= S_DIV_RATE;
                  end else begin
                     state_ff <= S_DONE;
                     if (too_long) begin
                        last_ff <= now_ff;
                     end
                  end
               end else begin
                  armed_ff <= armed_ff || arm_hit;
                  state_ff <= S_DONE;
               end
            end
            S_DIV_RATE: begin
               div_rem_ff <= div_rem_in;
               div_quo_ff <= div_quo_in;
               div_cnt_ff <= div_cnt_ff + 1'b1;
               if (div_last) begin
                  state_ff <= S_STORE;
               end
            end
            S_STORE: begin
               history_ff[slot_ff] <= raw_sat;
               slot_ff     <= (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
               last_ff     <= now_ff;
               res_beat_ff <= 1'b1;
               sum_ff      <= '0;
               cnt_ff      <= '0;
               idx_ff      <= '0;
               state_ff    <= S_SUM;
            end
            S_SUM: begin
               if (history_ff[idx_ff] != '0) begin
                  sum_ff <= sum_ff + SUM_W'(history_ff[idx_ff]);
                  cnt_ff <= cnt_ff + 1'b1;
               end
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == SLOT_LAST) begin
                  state_ff <= S_MEAN;
               end
            end
            S_MEAN: begin
               if (cnt_ff == '0) begin
                  res_rate_ff <= '0;
                  state_ff    <= S_DONE;
               end else begin
                  div_rem_ff <= '0;
                  div_quo_ff <= DIV_W'(sum_ff);
                  div_den_ff <= DIV_W'(cnt_ff);
                  div_cnt_ff <= '0;
                  state_ff   <= S_DIV_MEAN;
               end
            end
            S_DIV_MEAN: begin
               div_rem_ff <= div_rem_in;
               div_quo_ff <= div_quo_in;
               div_cnt_ff <= div_cnt_ff + 1'b1;
               if (div_last) begin
                  res_rate_ff <= div_quo_in[RATE_W-1:0];
                  state_ff    <= S_DONE;
               end
            end
            S_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_finger_ff <= res_finger_ff;
                  rsp_ac_ff     <= res_ac_ff;
                  rsp_beat_ff   <= res_beat_ff;
                  rsp_rate_ff   <= res_rate_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready          = state_ff == S_IDLE;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_finger_present = rsp_finger_ff;
   assign rsp_ac_value       = rsp_ac_ff;
   assign rsp_beat           = rsp_beat_ff;
   assign rsp_rate_bpm       = rsp_rate_ff;

   `PBRD_ASSERT_SAME(a_beat_needs_finger, clock, reset, rsp_valid && rsp_beat, rsp_finger_present)
   `PBRD_ASSERT_SAME(a_no_finger_quiet, clock, reset, rsp_valid && !rsp_finger_present,
                     rsp_ac_value == '0 && rsp_rate_bpm == '0)
   `PBRD_ASSERT_SAME(a_no_beat_no_rate, clock, reset, rsp_valid && !rsp_beat, rsp_rate_bpm == '0)
   `PBRD_ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && req_ready, state_ff == S_FILTER)

endmodule
